// ----- hw/rtl/cct_pkg.sv -----
// Package for the context count table: field widths, operation codes,
// counter limits and the structs passed between front and back.
// No dependencies.
package cct_pkg;

  localparam int MODE_W            = 2;
  localparam int INDEX_W           = 12;
  localparam int COUNT_W           = 32;
  localparam int HALV_W            = 32;
  localparam int TOTAL_W           = 64;
  localparam int DEF_CONTEXT_ORDER = 5;
  localparam int BANKS             = 4;
  localparam int BANK_W            = 2;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [1:0]        op_t;

  localparam mode_t MODE_UPDATE = 2'd0;
  localparam mode_t MODE_QUERY  = 2'd1;
  localparam mode_t MODE_ROW    = 2'd2;

  localparam op_t OP_UPDATE = 2'd0;
  localparam op_t OP_QUERY  = 2'd1;
  localparam op_t OP_ROW    = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  // value of a saturated counter after halving and incrementing
  localparam logic [COUNT_W-1:0] HALVED_PLUS_ONE = (COUNT_MAX >> 1) + COUNT_W'(1);
  localparam logic [HALV_W-1:0]  HALV_MAX        = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] base;
  } cct_item_t;

  // front to back: head of the queue
  typedef struct packed {
    logic      valid;
    cct_item_t item;
  } cct_fe_t;

  // back to front: pop and clearing status
  typedef struct packed {
    logic clearing;
    logic pop;
  } cct_be_t;

endpackage

// ----- hw/rtl/cct_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module cct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/cct_front.sv -----
// Front end of the context count table: accepts input words, maps the
// mode to an operation and holds them in a two-entry queue. Uses cct_pkg.
module cct_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cct_pkg::MODE_W-1:0]  mode,
  input  logic [cct_pkg::INDEX_W-1:0] context_index,
  input  cct_pkg::cct_be_t            be,
  output cct_pkg::cct_fe_t            fe
);

  import cct_pkg::*;

  cct_item_t   slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt;
  logic        push;
  cct_item_t   item_in;

  always_comb begin
    item_in.base = context_index;
    case (mode)
      MODE_UPDATE: item_in.op = OP_UPDATE;
      MODE_ROW:    item_in.op = OP_ROW;
      default:     item_in.op = OP_QUERY;  // unused code reads one counter
    endcase
  end

  // hold the input off while the queue is full or the table is being cleared
  assign in_stall = (cnt == 2'd2) || be.clearing;
  assign push     = in_valid && !in_stall;

  assign fe.valid = (cnt != 2'd0);
  assign fe.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (be.pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, be.pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- hw/rtl/cct_back.sv -----
// Back end of the context count table: four banked counter RAMs, clearing
// pass, whole-table halving walk, tallies and the output register.
// Uses cct_pkg and cct_ram.
module cct_back #(
  parameter int CONTEXT_ORDER = cct_pkg::DEF_CONTEXT_ORDER
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cct_pkg::cct_fe_t            fe,
  output cct_pkg::cct_be_t            be,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cct_pkg::COUNT_W-1:0] count_a,
  output logic [cct_pkg::COUNT_W-1:0] count_b,
  output logic [cct_pkg::COUNT_W-1:0] count_c,
  output logic [cct_pkg::COUNT_W-1:0] count_d,
  output logic [cct_pkg::HALV_W-1:0]  halvings_done,
  output logic [cct_pkg::TOTAL_W-1:0] update_total
);

  import cct_pkg::*;

  localparam int ADDR_W = 2 * (CONTEXT_ORDER + 1);
  localparam int ROW_W  = ADDR_W - BANK_W;
  localparam int ROWS   = 1 << ROW_W;
  localparam int SUM_W  = (ADDR_W > INDEX_W + 1) ? ADDR_W : INDEX_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_HALVE = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]         state;
  logic [ROW_W-1:0]   clr_cnt;
  logic [ROW_W:0]     hw_cnt;
  logic [ROW_W:0]     hw_prev;
  logic [BANK_W-1:0]  cur_lo;
  op_t                cur_op;
  logic [ROW_W-1:0]   cur_row [BANKS];
  logic [HALV_W-1:0]  halving_tally;
  logic [TOTAL_W-1:0] update_tally;
  logic [TOTAL_W-1:0] update_next;

  logic [BANK_W-1:0]  off     [BANKS];
  logic [SUM_W-1:0]   sum     [BANKS];
  logic [ROW_W-1:0]   iss_row [BANKS];

  logic               we      [BANKS];
  logic [ROW_W-1:0]   waddr   [BANKS];
  logic [COUNT_W-1:0] wdata   [BANKS];
  logic               re;
  logic [ROW_W-1:0]   raddr   [BANKS];
  logic [COUNT_W-1:0] rdata   [BANKS];

  logic               out_free;
  logic               pop;
  logic [COUNT_W-1:0] rd_sel;
  logic               rd_max;
  logic               emit;
  logic               upd_wr;
  logic [COUNT_W-1:0] new_val;
  logic               walk_end;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && fe.valid;
  assign rd_sel   = rdata[cur_lo];
  assign rd_max   = (rd_sel == COUNT_MAX);
  assign hw_prev  = hw_cnt - (ROW_W + 1)'(1);
  assign walk_end = (state == S_HALVE) && (hw_cnt == (ROW_W + 1)'(ROWS));
  assign new_val  = (state == S_WRITE) ? HALVED_PLUS_ONE : rd_sel + COUNT_W'(1);

  assign be.pop      = pop;
  assign be.clearing = (state == S_CLEAR);

  // a saturated counter on update diverts to the halving walk first
  assign upd_wr = out_free &&
                  (((state == S_EXEC) && (cur_op == OP_UPDATE) && !rd_max) ||
                   (state == S_WRITE));
  assign emit   = upd_wr || (out_free && (state == S_EXEC) && (cur_op != OP_UPDATE));

  assign update_next = (update_tally == TOTAL_MAX) ? update_tally
                                                   : update_tally + TOTAL_W'(1);

  // row in each bank for the four words starting at the queued index
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      off[b]     = BANK_W'(b) - fe.item.base[BANK_W-1:0];
      sum[b]     = SUM_W'(fe.item.base) + SUM_W'(off[b]);
      iss_row[b] = sum[b][ADDR_W-1:BANK_W];
    end
  end

  always_comb begin
    re = pop || ((state == S_HALVE) && (hw_cnt != (ROW_W + 1)'(ROWS)));
    for (int b = 0; b < BANKS; b++) begin
      raddr[b] = (state == S_HALVE) ? hw_cnt[ROW_W-1:0] : iss_row[b];
      we[b]    = 1'b0;
      waddr[b] = cur_row[b];
      wdata[b] = new_val;
      if (state == S_CLEAR) begin
        we[b]    = 1'b1;
        waddr[b] = clr_cnt;
        wdata[b] = '0;
      end else if (state == S_HALVE) begin
        // write back the row read on the previous cycle
        we[b]    = (hw_cnt != '0);
        waddr[b] = hw_prev[ROW_W-1:0];
        wdata[b] = rdata[b] >> 1;
      end else if (upd_wr && (BANK_W'(b) == cur_lo)) begin
        we[b] = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    cct_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr (waddr[g]),
      .wdata (wdata[g]),
      .re    (re),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op <= fe.item.op;
      cur_lo <= fe.item.base[BANK_W-1:0];
      for (int b = 0; b < BANKS; b++) begin
        cur_row[b] <= iss_row[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      hw_cnt        <= '0;
      halving_tally <= '0;
      update_tally  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ROW_W'(1);
          if (clr_cnt == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if ((cur_op == OP_UPDATE) && rd_max) begin
            hw_cnt <= '0;
            state  <= S_HALVE;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_HALVE: begin
          hw_cnt <= hw_cnt + (ROW_W + 1)'(1);
          if (walk_end) begin
            if (halving_tally != HALV_MAX) begin
              halving_tally <= halving_tally + HALV_W'(1);
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (upd_wr) begin
        update_tally <= update_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      count_a       <= (cur_op == OP_UPDATE) ? new_val : rd_sel;
      count_b       <= (cur_op == OP_ROW) ? rdata[cur_lo + BANK_W'(1)] : '0;
      count_c       <= (cur_op == OP_ROW) ? rdata[cur_lo + BANK_W'(2)] : '0;
      count_d       <= (cur_op == OP_ROW) ? rdata[cur_lo + BANK_W'(3)] : '0;
      halvings_done <= halving_tally;
      update_total  <= upd_wr ? update_next : update_tally;
    end
  end

`ifndef SYNTHESIS
  a_no_out_while_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result presented during clearing pass");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_EXEC))
    else $error("queue popped without starting execution");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_HALVE) |-> (hw_cnt <= (ROW_W + 1)'(ROWS)))
    else $error("halving walk ran past the table");

  a_halv_only_walk: assert property (@(posedge clk) disable iff (rst)
    (!$stable(halving_tally) && !$past(rst)) |-> ($past(state) == S_HALVE))
    else $error("halving tally moved outside a walk");

  a_total_with_emit: assert property (@(posedge clk) disable iff (rst)
    (!$stable(update_tally) && !$past(rst)) |-> ($past(emit) && out_valid))
    else $error("update tally moved without a result");
`endif

endmodule

// ----- hw/rtl/context_count_table_halving.sv -----
// Context count table with whole-table halving. After reset the block runs a
// clearing pass over every row with in_stall high; the table sits in four RAM
// banks split on the low two index bits, each with one read port, so a row of
// four counters is read in one access. A query, row query or update is read,
// then resolved and, for an update, written back in the back end. An update
// that finds its counter saturated first runs a halving walk over all banks in
// parallel, then writes the counter. A two-word queue lets the input run ahead
// of execution, and the output register holds a result while the back end
// moves on. Uses cct_pkg, cct_front and cct_back.
module context_count_table_halving #(
  parameter int CONTEXT_ORDER = cct_pkg::DEF_CONTEXT_ORDER
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cct_pkg::MODE_W-1:0]  mode,
  input  logic [cct_pkg::INDEX_W-1:0] context_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cct_pkg::COUNT_W-1:0] count_a,
  output logic [cct_pkg::COUNT_W-1:0] count_b,
  output logic [cct_pkg::COUNT_W-1:0] count_c,
  output logic [cct_pkg::COUNT_W-1:0] count_d,
  output logic [cct_pkg::HALV_W-1:0]  halvings_done,
  output logic [cct_pkg::TOTAL_W-1:0] update_total
);

  import cct_pkg::*;

  cct_fe_t fe;
  cct_be_t be;

  cct_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .context_index (context_index),
    .be            (be),
    .fe            (fe)
  );

  cct_back #(
    .CONTEXT_ORDER (CONTEXT_ORDER)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .fe            (fe),
    .be            (be),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .count_a       (count_a),
    .count_b       (count_b),
    .count_c       (count_c),
    .count_d       (count_d),
    .halvings_done (halvings_done),
    .update_total  (update_total)
  );

endmodule

// ----- bench/context_count_table_halving_test.sv -----
// Self-checking bench for context_count_table_halving: a clocked driver feeds
// command words from a queue, a clocked monitor checks each result word.
// Depends on cct_pkg and the context_count_table_halving RTL.
module context_count_table_halving_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cct_pkg::*;

  localparam int ORDER          = DEF_CONTEXT_ORDER;
  localparam int TBL_SIZE       = 4 << (2 * ORDER);
  localparam int RANDOM_WORDS   = 750;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 150;
  localparam int HOLD_AFTER     = 200;
  localparam mode_t MODE_SPARE  = 2'd3;

  typedef struct packed {
    mode_t              mode;
    logic [INDEX_W-1:0] ctx;
  } cmd_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] a;
    logic [COUNT_W-1:0] b;
    logic [COUNT_W-1:0] c;
    logic [COUNT_W-1:0] d;
    logic [HALV_W-1:0]  halv;
    logic [TOTAL_W-1:0] total;
  } count_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mode_t              mode = MODE_UPDATE;
  logic [INDEX_W-1:0] context_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] count_a;
  logic [COUNT_W-1:0] count_b;
  logic [COUNT_W-1:0] count_c;
  logic [COUNT_W-1:0] count_d;
  logic [HALV_W-1:0]  halvings_done;
  logic [TOTAL_W-1:0] update_total;

  context_count_table_halving #(
    .CONTEXT_ORDER(ORDER)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .context_index(context_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .count_a      (count_a),
    .count_b      (count_b),
    .count_c      (count_c),
    .count_d      (count_d),
    .halvings_done(halvings_done),
    .update_total (update_total)
  );

  // shadow of the counter table and the two tallies
  logic [COUNT_W-1:0] ctr_mem [TBL_SIZE];
  logic [HALV_W-1:0]  halv_tally = '0;
  logic [TOTAL_W-1:0] upd_tally = '0;

  cmd_word_t  pending_words[$];
  count_res_t results_due[$];
  int         errors = 0;
  int         results_seen = 0;
  logic       idle_ok = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  int         quiet_cycles = 0;
  logic [INDEX_W-1:0] hot_ctx [16];

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow table and return the word it should yield.
  // Counter saturation needs 2^32 updates, so halving is modelled but not reached.
  function automatic count_res_t count_table_step(mode_t m, logic [INDEX_W-1:0] ctx);
    count_res_t r;
    int unsigned a;
    int          i;
    r = '0;
    a = ctx & (TBL_SIZE - 1);
    if (m == MODE_UPDATE) begin
      if (ctr_mem[a] == COUNT_MAX) begin
        for (i = 0; i < TBL_SIZE; i++) ctr_mem[i] = ctr_mem[i] >> 1;
        if (halv_tally != HALV_MAX) halv_tally = halv_tally + 1'b1;
      end
      ctr_mem[a] = ctr_mem[a] + 1'b1;
      if (upd_tally != TOTAL_MAX) upd_tally = upd_tally + 1'b1;
      r.a = ctr_mem[a];
    end else if (m == MODE_ROW) begin
      r.a = ctr_mem[a];
      r.b = ctr_mem[(ctx + 1) & (TBL_SIZE - 1)];
      r.c = ctr_mem[(ctx + 2) & (TBL_SIZE - 1)];
      r.d = ctr_mem[(ctx + 3) & (TBL_SIZE - 1)];
    end else begin
      r.a = ctr_mem[a];
    end
    r.halv  = halv_tally;
    r.total = upd_tally;
    return r;
  endfunction

  task automatic queue_word(mode_t m, logic [INDEX_W-1:0] ctx);
    cmd_word_t w;
    w.mode = m;
    w.ctx  = ctx;
    pending_words.push_back(w);
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  // driver: hold a stalled word, otherwise advance to the next or idle
  always @(posedge clk) begin : drive_proc
    cmd_word_t w;
    logic      in_fire;
    if (rst) begin
      in_valid <= 1'b0;
      idle_ok  <= 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) results_due.push_back(count_table_step(mode, context_index));
      // idle only outside the tail, and in stretches, not everywhere
      idle_ok <= (pending_words.size() > 120) && (((pending_words.size() >> 6) % 3) != 0);
      if (in_valid && !in_fire) begin
        // hold
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (in_fire && idle_ok && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(1, 6) - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid      <= 1'b1;
        mode          <= w.mode;
        context_index <= w.ctx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold-off to fill the block, then random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_ok && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_proc
    count_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word, count_a 0x%0h", $time, count_a);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("count_a", want.a, count_a);
        check_field("count_b", want.b, count_b);
        check_field("count_c", want.c, count_c);
        check_field("count_d", want.d, count_d);
        check_field("halvings_done", want.halv, halvings_done);
        check_field("update_total", want.total, update_total);
      end
    end
  end

  // watchdog: cycles with no word accepted on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("context_count_table_halving regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim_proc
    int i;
    int pick;
    mode_t m;
    logic [INDEX_W-1:0] ctx;
    for (i = 0; i < TBL_SIZE; i++) ctr_mem[i] = '0;

    // directed: table ends, row wrap-around, spare mode, fresh zero counters
    queue_word(MODE_QUERY, 12'd0);
    queue_word(MODE_ROW, 12'd4095);
    queue_word(MODE_UPDATE, 12'd0);
    queue_word(MODE_UPDATE, 12'd4095);
    queue_word(MODE_UPDATE, 12'd0);
    queue_word(MODE_UPDATE, 12'd1);
    queue_word(MODE_UPDATE, 12'd2);
    queue_word(MODE_UPDATE, 12'd4094);
    queue_word(MODE_UPDATE, 12'd4093);
    queue_word(MODE_UPDATE, 12'd2730);
    queue_word(MODE_UPDATE, 12'd1365);
    queue_word(MODE_QUERY, 12'd0);
    queue_word(MODE_QUERY, 12'd4095);
    queue_word(MODE_QUERY, 12'd3);
    queue_word(MODE_ROW, 12'd0);
    queue_word(MODE_ROW, 12'd4093);
    queue_word(MODE_ROW, 12'd4094);
    queue_word(MODE_ROW, 12'd4095);
    queue_word(MODE_ROW, 12'd1364);
    queue_word(MODE_SPARE, 12'd0);
    queue_word(MODE_SPARE, 12'd4095);
    queue_word(MODE_SPARE, 12'd2730);
    queue_word(MODE_UPDATE, 12'd4095);
    queue_word(MODE_ROW, 12'd4095);

    // a small hot set makes counters climb; the rest spreads over all indices
    for (i = 0; i < 4; i++) begin
      hot_ctx[i]     = INDEX_W'(i);
      hot_ctx[i + 4] = INDEX_W'(TBL_SIZE - 4 + i);
    end
    for (i = 8; i < 16; i++) hot_ctx[i] = INDEX_W'($urandom_range(0, TBL_SIZE - 1));
    for (i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) m = MODE_UPDATE;
      else if (pick < 14) m = MODE_QUERY;
      else if (pick < 19) m = MODE_ROW;
      else m = MODE_SPARE;
      if ($urandom_range(0, 9) < 6) ctx = hot_ctx[$urandom_range(0, 15)];
      else ctx = INDEX_W'($urandom_range(0, TBL_SIZE - 1));
      queue_word(m, ctx);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || results_due.size() != 0);
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("context_count_table_halving regression: pass");
    end else begin
      $display("context_count_table_halving regression: fail");
    end
    $finish;
  end

endmodule
